[hdl/fss_pkg.sv]
// ---------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and the duty-to-rpm curve of the fan supervisor.
// ---------------------------------------------------------------------------
package fss_pkg;

	localparam int DEFAULT_PERIOD_BITS = 24;

	// duty curve, permille in, rpm out
	localparam int TABLE_POINTS = 13;
	localparam int SEG_W        = $clog2(TABLE_POINTS - 1);

	localparam logic [9:0] CURVE_DUTY [TABLE_POINTS] = '{
		10'd282, 10'd290, 10'd330, 10'd376, 10'd420, 10'd469, 10'd517,
		10'd573, 10'd634, 10'd695, 10'd761, 10'd829, 10'd910
	};
	localparam logic [11:0] CURVE_RPM [TABLE_POINTS] = '{
		12'd1480, 12'd1530, 12'd1700, 12'd1870, 12'd2040, 12'd2210, 12'd2380,
		12'd2550, 12'd2725, 12'd2890, 12'd3060, 12'd3240, 12'd3400
	};

	// running mean weight, a power of two
	localparam int MEAN_WEIGHT = 8;
	localparam int MEAN_SHIFT  = $clog2(MEAN_WEIGHT);
	localparam int MEAN_SUM_W  = 10 + MEAN_SHIFT + 1;

	localparam logic [9:0]  DUTY_MIN  = 10'd35;
	localparam logic [9:0]  DUTY_MAX  = 10'd950;
	localparam logic [11:0] RPM_MIN   = 12'd500;
	localparam logic [11:0] RPM_MAX   = 12'd3800;
	localparam logic [11:0] EMU_LOW   = 12'd1300;
	localparam logic [11:0] EMU_HIGH  = 12'd3450;
	localparam logic [9:0]  CMD_RESET = 10'd150;

	// 60 s * 1e9 / 25 ns / two pulses per revolution... folded into one numerator
	localparam int          NUM_BITS      = 31;
	localparam logic [30:0] RPM_NUMERATOR = 31'd1200000000;

	// interpolation numerator (dx * dy) stays below 2^15 for this curve
	localparam int INTERP_BITS = 15;

	// configuration register indexes
	localparam int REG_INDEX_W = 4;
	localparam int REG_DATA_W  = 12;
	localparam logic [REG_INDEX_W-1:0] REG_SILENT_ENTER  = 4'd0;
	localparam logic [REG_INDEX_W-1:0] REG_SILENT_EXIT   = 4'd1;
	localparam logic [REG_INDEX_W-1:0] REG_FAULT_DEV     = 4'd2;
	localparam logic [REG_INDEX_W-1:0] REG_RECOVER_DEV   = 4'd3;
	localparam logic [REG_INDEX_W-1:0] REG_RECOVER_MIN   = 4'd4;
	localparam logic [REG_INDEX_W-1:0] REG_STALL_RPM     = 4'd5;
	localparam logic [REG_INDEX_W-1:0] REG_SILENT_DUTY   = 4'd6;
	localparam logic [REG_INDEX_W-1:0] REG_FALLBACK_DUTY = 4'd7;

	typedef enum logic [1:0] {
		MODE_STANDARD = 2'd0,
		MODE_SILENT   = 2'd1,
		MODE_FALLBACK = 2'd2
	} mode_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[hdl/fan_speed_supervisor.sv]
// A tick runs from acceptance to result through the sequencer states RPM_GO,
// RPM_WAIT, EMU_GO, EMU_WAIT and DECIDE: the shared restoring divider runs 31
// steps for the fan rpm and 15 for the curve interpolation; a duty outside the
// curve's range skips the second division. The next word can be accepted in
// the cycle after the result is registered. A new word is accepted only once
// the previous one has been handed to the output register, and the result
// then waits there while the next tick runs.
// ---------------------------------------------------------------------------
// fan_speed_supervisor
// GPU fan supervisor: sanitises the requested duty, measures fan rpm, emulates
// the tacho rpm from a duty curve and runs the standard/silent/fallback modes.
// ---------------------------------------------------------------------------
module fan_speed_supervisor
	import fss_pkg::*;
#(
	parameter int PERIOD_BITS = DEFAULT_PERIOD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [9:0]              gpu_duty,
	input  logic [PERIOD_BITS-1:0]  tacho_period,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [9:0]              fan_duty,
	output logic [11:0]             emulated_rpm,
	output logic [11:0]             fan_rpm,
	output logic signed [12:0]      rpm_deviation,
	output logic [1:0]              mode,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [REG_INDEX_W-1:0]  cfg_index,
	input  logic [REG_DATA_W-1:0]   cfg_data
);

	localparam int DIV_W = (PERIOD_BITS > NUM_BITS) ? PERIOD_BITS : NUM_BITS;
	localparam int CNT_W = $clog2(DIV_W + 1);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_RPM_GO   = 6'b000010,
		S_RPM_WAIT = 6'b000100,
		S_EMU_GO   = 6'b001000,
		S_EMU_WAIT = 6'b010000,
		S_DECIDE   = 6'b100000
	} state_t;

	state_t state_q;

	// configuration
	logic [9:0]  silent_enter_q, silent_exit_q, silent_duty_q, fallback_duty_q;
	logic [11:0] fault_dev_q, recover_dev_q, recover_min_q, stall_rpm_q;

	// control state
	mode_t      mode_q;
	logic [9:0] mean_q;
	logic [9:0] cmd_q;

	// per-tick working registers
	logic [9:0]             d_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [INTERP_BITS-1:0] interp_num_q;
	logic [9:0]             span_q;
	logic [11:0]            y0_q;
	logic                   below_q, above_q;
	logic [11:0]            rpm_q;
	logic [11:0]            emu_q;

	// output register
	logic        out_valid_q;
	logic [9:0]  out_duty_q;
	logic [11:0] out_emu_q, out_rpm_q;
	logic [12:0] out_dev_q;
	mode_t       out_mode_q;

	// divider
	logic             div_start;
	logic [DIV_W-1:0] div_num, div_den, div_quot;
	logic [CNT_W-1:0] div_steps;
	div_stat_t        div_stat;

	fss_divider #(.W(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.den      (div_den),
		.steps    (div_steps),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	logic in_fire, decide_fire;
	assign in_stall    = (state_q != S_IDLE);
	assign in_fire     = in_valid && !in_stall;
	assign decide_fire = (state_q == S_DECIDE) && (!out_valid_q || !out_stall);
	assign cfg_ready   = 1'b1;

	// segment search: first segment whose upper point covers the duty
	logic [SEG_W-1:0] seg;
	always_comb begin
		seg = SEG_W'(TABLE_POINTS - 2);
		for (int i = TABLE_POINTS - 2; i >= 0; i--) begin
			if (d_q <= CURVE_DUTY[i+1]) begin
				seg = SEG_W'(i);
			end
		end
	end

	logic [9:0]  seg_dx, seg_span;
	logic [11:0] seg_dy;
	logic [21:0] seg_prod;
	assign seg_dx   = d_q - CURVE_DUTY[seg];
	assign seg_span = CURVE_DUTY[seg+SEG_W'(1)] - CURVE_DUTY[seg];
	assign seg_dy   = CURVE_RPM[seg+SEG_W'(1)] - CURVE_RPM[seg];
	assign seg_prod = seg_dx * seg_dy;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_steps = '0;
		if (state_q == S_RPM_GO) begin
			div_start = 1'b1;
			div_num   = DIV_W'(RPM_NUMERATOR) << (DIV_W - NUM_BITS);
			div_den   = DIV_W'(period_q);
			div_steps = CNT_W'(NUM_BITS);
		end else if (state_q == S_EMU_GO && !below_q && !above_q) begin
			div_start = 1'b1;
			div_num   = DIV_W'(interp_num_q) << (DIV_W - INTERP_BITS);
			div_den   = DIV_W'(span_q);
			div_steps = CNT_W'(INTERP_BITS);
		end
	end

	// rpm check on the raw quotient
	logic rpm_ok;
	assign rpm_ok = (period_q != '0) && (div_quot >= DIV_W'(RPM_MIN))
		&& (div_quot <= DIV_W'(RPM_MAX));

	// mode decision
	logic signed [13:0]    dev;
	logic [MEAN_SUM_W-1:0] mean_sum;
	logic [9:0]            mean_next;
	logic [9:0]            cmd_next;
	mode_t                 mode_next;

	assign dev       = $signed({2'b00, emu_q}) - $signed({2'b00, rpm_q});
	assign mean_sum  = MEAN_SUM_W'(mean_q) * MEAN_SUM_W'(MEAN_WEIGHT - 1) + MEAN_SUM_W'(d_q);
	assign mean_next = 10'(mean_sum >> MEAN_SHIFT);

	always_comb begin
		cmd_next  = cmd_q;
		mode_next = mode_q;
		unique case (mode_q)
			MODE_STANDARD: begin
				cmd_next = mean_next;
				if (dev > $signed({2'b00, fault_dev_q})) begin
					mode_next = MODE_FALLBACK;
				end else if (d_q < silent_enter_q) begin
					mode_next = MODE_SILENT;
				end
			end
			MODE_SILENT: begin
				cmd_next = silent_duty_q;
				if (rpm_q < stall_rpm_q) begin
					mode_next = MODE_FALLBACK;
				end else if (d_q > silent_exit_q) begin
					mode_next = MODE_STANDARD;
				end
			end
			default: begin
				// recovery keeps the previous command
				if (dev < $signed({2'b00, recover_dev_q}) && rpm_q > recover_min_q) begin
					mode_next = MODE_STANDARD;
				end else begin
					cmd_next  = fallback_duty_q;
					mode_next = MODE_FALLBACK;
				end
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:     if (in_fire) state_q <= S_RPM_GO;
				S_RPM_GO:   state_q <= S_RPM_WAIT;
				S_RPM_WAIT: if (div_stat.done) state_q <= S_EMU_GO;
				S_EMU_GO:   state_q <= (below_q || above_q) ? S_DECIDE : S_EMU_WAIT;
				S_EMU_WAIT: if (div_stat.done) state_q <= S_DECIDE;
				S_DECIDE:   if (decide_fire) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			d_q      <= (gpu_duty < DUTY_MIN || gpu_duty > DUTY_MAX) ? DUTY_MAX : gpu_duty;
			period_q <= tacho_period;
		end
		if (state_q == S_RPM_GO) begin
			below_q      <= (d_q < CURVE_DUTY[0]);
			above_q      <= (d_q > CURVE_DUTY[TABLE_POINTS-1]);
			interp_num_q <= seg_prod[INTERP_BITS-1:0];
			span_q       <= seg_span;
			y0_q         <= CURVE_RPM[seg];
		end
		if (state_q == S_RPM_WAIT && div_stat.done) begin
			rpm_q <= rpm_ok ? div_quot[11:0] : RPM_MIN;
		end
		if (state_q == S_EMU_GO) begin
			emu_q <= below_q ? EMU_LOW : EMU_HIGH;
		end
		if (state_q == S_EMU_WAIT && div_stat.done) begin
			emu_q <= y0_q + div_quot[11:0];
		end
		if (decide_fire) begin
			out_duty_q <= cmd_next;
			out_emu_q  <= emu_q;
			out_rpm_q  <= rpm_q;
			out_dev_q  <= dev[12:0];
			out_mode_q <= mode_next;
		end
	end

	// control state, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_STANDARD;
			mean_q          <= '0;
			cmd_q           <= CMD_RESET;
			out_valid_q     <= 1'b0;
			silent_enter_q  <= 10'd310;
			silent_exit_q   <= 10'd350;
			fault_dev_q     <= 12'd500;
			recover_dev_q   <= 12'd100;
			recover_min_q   <= 12'd600;
			stall_rpm_q     <= 12'd500;
			silent_duty_q   <= 10'd150;
			fallback_duty_q <= 10'd900;
		end else begin
			if (decide_fire) begin
				mode_q      <= mode_next;
				mean_q      <= mean_next;
				cmd_q       <= cmd_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SILENT_ENTER:  silent_enter_q  <= cfg_data[9:0];
					REG_SILENT_EXIT:   silent_exit_q   <= cfg_data[9:0];
					REG_FAULT_DEV:     fault_dev_q     <= cfg_data;
					REG_RECOVER_DEV:   recover_dev_q   <= cfg_data;
					REG_RECOVER_MIN:   recover_min_q   <= cfg_data;
					REG_STALL_RPM:     stall_rpm_q     <= cfg_data;
					REG_SILENT_DUTY:   silent_duty_q   <= cfg_data[9:0];
					REG_FALLBACK_DUTY: fallback_duty_q <= cfg_data[9:0];
					default: ;
				endcase
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign fan_duty      = out_duty_q;
	assign emulated_rpm  = out_emu_q;
	assign fan_rpm       = out_rpm_q;
	assign rpm_deviation = $signed(out_dev_q);
	assign mode          = out_mode_q;

	// checks
	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DECIDE))
		else $error("result appeared outside the decide step");

	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_dev_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_dev_q == (13'(out_emu_q) - 13'(out_rpm_q)))
		else $error("deviation does not match emulated and fan rpm");

	a_rpm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_rpm_q >= RPM_MIN && out_rpm_q <= RPM_MAX))
		else $error("fan rpm outside clamp range");

endmodule

[hdl/fss_divider.sv]
// ---------------------------------------------------------------------------
// fss_divider
// Restoring divider, one quotient bit per clock, shared by the rpm and the
// curve interpolation. The numerator arrives left-aligned so that only the
// requested number of steps is run.
// ---------------------------------------------------------------------------
module fss_divider
	import fss_pkg::*;
#(
	parameter int W = NUM_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [W-1:0]           num,
	input  logic [W-1:0]           den,
	input  logic [$clog2(W+1)-1:0] steps,
	output logic [W-1:0]           quotient,
	output div_stat_t              stat
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     num_q;
	logic [W-1:0]     den_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;

	assign trial = {rem_q, num_q[W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = ~diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// quotient bits shift in behind the numerator
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			num_q <= {num_q[W-2:0], ge};
		end
	end

	assign quotient  = num_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule
